FILE: design/ffcc_pkg.sv
// Shared types and constants of the floor and ceiling texture caster.
// Used by the front end, back end and top level of the block; depends on nothing.
`default_nettype none
package ffcc_pkg;

	localparam int COORD_W     = 48;
	localparam int QUEUE_DEPTH = 4;
	localparam logic [31:0] DARKEN_MASK = 32'd8355711;
	localparam logic [26:0] RD_SAT      = 27'd67108863;

	localparam logic [1:0] REQ_LOAD_FLOOR = 2'd0;
	localparam logic [1:0] REQ_LOAD_CEIL  = 2'd1;
	localparam logic [1:0] REQ_RENDER     = 2'd2;

	localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_VIEW_POS_X    = 3'd2;
	localparam logic [2:0] CFG_VIEW_POS_Y    = 3'd3;
	localparam logic [2:0] CFG_VIEW_DIR_X    = 3'd4;
	localparam logic [2:0] CFG_VIEW_DIR_Y    = 3'd5;
	localparam logic [2:0] CFG_CAM_PLANE_X   = 3'd6;
	localparam logic [2:0] CFG_CAM_PLANE_Y   = 3'd7;

	typedef struct packed {
		logic [10:0]        screen_width;
		logic [10:0]        screen_height;
		logic [23:0]        view_pos_x;
		logic [23:0]        view_pos_y;
		logic signed [15:0] view_dir_x;
		logic signed [15:0] view_dir_y;
		logic signed [15:0] cam_plane_x;
		logic signed [15:0] cam_plane_y;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [11:0] texel_index;
		logic [31:0] texel_color;
	} item_t;

	typedef struct packed {
		logic [9:0]  screen_row;
		logic [9:0]  screen_column;
		logic [31:0] pixel_color;
		logic        surface_kind;
		logic        last_of_run;
	} beat_t;

endpackage
`default_nettype wire

FILE: design/ffcc_front.sv
// Front end: takes input beats, drops unknown requests and queues the rest.
// Depends on ffcc_pkg.
`default_nettype none
module ffcc_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire logic [47:0]    s_tdata,   // texel_index[11:0], texel_color[43:12]
	input  wire logic [1:0]     s_tuser,   // req_type[1:0]
	output logic                q_valid,
	output ffcc_pkg::item_t     q_item,
	input  wire logic           q_pop
);
	localparam int PW = $clog2(ffcc_pkg::QUEUE_DEPTH);

	ffcc_pkg::item_t     mem_q [ffcc_pkg::QUEUE_DEPTH];
	logic [PW-1:0]       wr_ptr_q, rd_ptr_q;
	logic [PW:0]         count_q;
	logic                push, pop;

	assign s_tready = (count_q != (PW+1)'(ffcc_pkg::QUEUE_DEPTH));
	assign push     = s_tvalid && s_tready && (s_tuser == ffcc_pkg::REQ_LOAD_FLOOR ||
		s_tuser == ffcc_pkg::REQ_LOAD_CEIL || s_tuser == ffcc_pkg::REQ_RENDER);
	assign q_valid  = (count_q != '0);
	assign pop      = q_valid && q_pop;
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{req_type: s_tuser, texel_index: s_tdata[11:0],
				texel_color: s_tdata[43:12]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW+1)'(ffcc_pkg::QUEUE_DEPTH)) else $error("queue overflow");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && !q_valid |=> count_q == $past(count_q) || push == 1'b0 || 1'b1)
		else $error("pop bookkeeping");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1) else $error("count slip");
`endif
endmodule
`default_nettype wire

FILE: design/ffcc_div.sv
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on nothing beyond its parameters.
`default_nettype none
module ffcc_div #(
	parameter int NW = 44,
	parameter int DW = 11
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               busy,
	output logic               done,
	output logic [NW-1:0]      quot
);
	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q, den_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [DW:0]   trial, diff;
	logic          fits;

	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(NW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quo_q;
endmodule
`default_nettype wire

FILE: design/ffcc_back.sv
// Back end: texture stores, row set-up sequencer, pixel stepping, output register.
// Depends on ffcc_pkg and ffcc_div.
`default_nettype none
module ffcc_back #(
	parameter int TEX_SIZE_LOG2 = 6,
	parameter int MAX_SCREEN    = 1024
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ffcc_pkg::cfg_t cfg,
	input  wire logic           q_valid,
	input  wire ffcc_pkg::item_t q_item,
	output logic                q_pop,
	output logic                m_valid,
	output ffcc_pkg::beat_t     m_beat,
	input  wire logic           m_ready
);
	localparam int TL  = TEX_SIZE_LOG2;
	localparam int AW  = 2 * TL;
	localparam int SW  = $clog2(MAX_SCREEN) + 1;
	localparam int RDW = (SW + 16 > 27) ? SW + 16 : 27;
	localparam int PW  = RDW + 17;
	localparam int CW  = ffcc_pkg::COORD_W;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_RD    = 8'b0000_0010,
		ST_MUL   = 8'b0000_0100,
		ST_USE   = 8'b0000_1000,
		ST_STEP  = 8'b0001_0000,
		ST_READ  = 8'b0010_0000,
		ST_EMIT0 = 8'b0100_0000,
		ST_EMIT1 = 8'b1000_0000
	} state_t;

	function automatic logic [TL-1:0] tex_coord(input logic [CW-1:0] v);
		logic [CW-1:0] m;
		logic [TL-1:0] t;
		m = v[CW-1] ? (~v + 1'b1) : v;
		t = m[23 -: TL];
		return v[CW-1] ? (~t + 1'b1) : t;
	endfunction

	state_t                 state_q;
	logic [SW-1:0]          row_q, col_q, w_q, h_q;
	logic [SW-1:0]          w_clamp, h_clamp, r1, r_n, c_n, posz, p_mag;
	logic signed [SW:0]     p_n;
	logic                   wrap_col, neg_q;
	logic [1:0]             k_q;
	logic signed [RDW-1:0]  rd_q;
	logic signed [PW-1:0]   prod_q, adj;
	logic [PW-1:0]          prod_mag;
	logic signed [16:0]     opb;
	logic [CW-1:0]          coord_x_q, coord_y_q, step_x_q, step_y_q, q_ext;
	logic [31:0]            tex_f_q, tex_c_q;
	logic [31:0]            floor_mem [2**AW];
	logic [31:0]            ceil_mem [2**AW];
	logic [AW-1:0]          waddr, raddr;
	logic                   we_f, we_c, rd_en, out_free;
	logic                   div_start, div_busy, div_done;
	logic [PW-1:0]          div_num, div_quot;
	logic [SW-1:0]          div_den;
	logic [SW-1:0]          col_inc, row_inc;
	logic                   m_valid_q;
	ffcc_pkg::beat_t        m_beat_q;

	// screen size clamp
	always_comb begin
		if (cfg.screen_width == '0)               w_clamp = SW'(1);
		else if (cfg.screen_width > MAX_SCREEN)   w_clamp = SW'(MAX_SCREEN);
		else                                      w_clamp = SW'(cfg.screen_width);
		if (cfg.screen_height < 11'd2)            h_clamp = SW'(2);
		else if (cfg.screen_height > MAX_SCREEN)  h_clamp = SW'(MAX_SCREEN);
		else                                      h_clamp = SW'(cfg.screen_height);
	end

	assign wrap_col = (col_q >= w_clamp);
	assign r1       = wrap_col ? row_q + 1'b1 : row_q;
	assign r_n      = (r1 >= h_clamp) ? '0 : r1;
	assign c_n      = wrap_col ? '0 : col_q;
	assign posz     = h_clamp >> 1;
	assign p_n      = $signed({1'b0, r_n}) - $signed({1'b0, posz});
	assign p_mag    = p_n[SW] ? SW'(-p_n) : SW'(p_n);

	always_comb begin
		case (k_q)
			2'd0:    opb = 17'(cfg.view_dir_x) - 17'(cfg.cam_plane_x);
			2'd1:    opb = 17'(cfg.view_dir_y) - 17'(cfg.cam_plane_y);
			2'd2:    opb = 17'(cfg.cam_plane_x);
			default: opb = 17'(cfg.cam_plane_y);
		endcase
	end

	// truncating division by 64 of the signed product
	assign adj      = prod_q + (prod_q[PW-1] ? PW'(63) : '0);
	assign prod_mag = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
	assign q_ext    = CW'(div_quot);

	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign we_f     = q_pop && (q_item.req_type == ffcc_pkg::REQ_LOAD_FLOOR);
	assign we_c     = q_pop && (q_item.req_type == ffcc_pkg::REQ_LOAD_CEIL);
	assign waddr    = AW'(q_item.texel_index);
	assign rd_en    = (state_q == ST_READ);
	assign raddr    = {tex_coord(coord_y_q), tex_coord(coord_x_q)};
	assign out_free = !m_valid_q || m_ready;

	assign div_start = (q_pop && q_item.req_type == ffcc_pkg::REQ_RENDER && c_n == '0
		&& p_n != '0) || (state_q == ST_USE && k_q[1]);
	assign div_num   = (state_q == ST_IDLE) ? PW'({posz, 16'b0}) : (prod_mag >> 5);
	assign div_den   = (state_q == ST_IDLE) ? p_mag : w_q;

	ffcc_div #(.NW(PW), .DW(SW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.busy  (div_busy),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk) begin
		if (we_f)  floor_mem[waddr] <= q_item.texel_color;
		if (rd_en) tex_f_q <= floor_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (we_c)  ceil_mem[waddr] <= q_item.texel_color;
		if (rd_en) tex_c_q <= ceil_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) prod_q <= rd_q * opb;
	end

	assign col_inc = col_q + 1'b1;
	assign row_inc = row_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			row_q     <= '0;
			col_q     <= '0;
			w_q       <= '0;
			h_q       <= '0;
			k_q       <= '0;
			neg_q     <= 1'b0;
			rd_q      <= '0;
			coord_x_q <= '0;
			coord_y_q <= '0;
			step_x_q  <= '0;
			step_y_q  <= '0;
			m_valid_q <= 1'b0;
			m_beat_q  <= '0;
		end else begin
			// the emit states reload the register themselves
			if (m_valid_q && m_ready && state_q != ST_EMIT0 && state_q != ST_EMIT1)
				m_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop && q_item.req_type == ffcc_pkg::REQ_RENDER) begin
						w_q   <= w_clamp;
						h_q   <= h_clamp;
						row_q <= r_n;
						col_q <= c_n;
						k_q   <= '0;
						neg_q <= p_n[SW];
						if (c_n != '0) begin
							state_q <= ST_READ;
						end else if (p_n == '0) begin
							rd_q    <= RDW'(ffcc_pkg::RD_SAT);
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					if (div_done) begin
						rd_q    <= neg_q ? -RDW'(div_quot) : RDW'(div_quot);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_USE;
				ST_USE: begin
					if (k_q == 2'd0) begin
						coord_x_q <= CW'({cfg.view_pos_x, 8'b0}) + CW'(adj >>> 6);
						k_q       <= k_q + 1'b1;
						state_q   <= ST_MUL;
					end else if (k_q == 2'd1) begin
						coord_y_q <= CW'({cfg.view_pos_y, 8'b0}) + CW'(adj >>> 6);
						k_q       <= k_q + 1'b1;
						state_q   <= ST_MUL;
					end else begin
						neg_q   <= prod_q[PW-1];
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (div_done) begin
						if (k_q == 2'd2) begin
							step_x_q <= neg_q ? -q_ext : q_ext;
							k_q      <= k_q + 1'b1;
							state_q  <= ST_MUL;
						end else begin
							step_y_q <= neg_q ? -q_ext : q_ext;
							state_q  <= ST_READ;
						end
					end
				end
				ST_READ: begin
					coord_x_q <= coord_x_q + step_x_q;
					coord_y_q <= coord_y_q + step_y_q;
					state_q   <= ST_EMIT0;
				end
				ST_EMIT0: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_beat_q  <= '{screen_row: 10'(row_q), screen_column: 10'(col_q),
							pixel_color: (tex_f_q >> 1) & ffcc_pkg::DARKEN_MASK,
							surface_kind: 1'b0, last_of_run: 1'b0};
						state_q   <= ST_EMIT1;
					end
				end
				ST_EMIT1: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_beat_q  <= '{screen_row: 10'(h_q - 1'b1 - row_q),
							screen_column: 10'(col_q),
							pixel_color: (tex_c_q >> 1) & ffcc_pkg::DARKEN_MASK,
							surface_kind: 1'b1, last_of_run: 1'b1};
						if (col_inc >= w_q) begin
							col_q <= '0;
							row_q <= (row_inc >= h_q) ? '0 : row_inc;
						end else begin
							col_q <= col_inc;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_valid = m_valid_q;
	assign m_beat  = m_beat_q;

`ifndef SYNTHESIS
	a_read_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> state_q == ST_EMIT0) else $error("read not followed by emit");
	a_div_start_place: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (state_q == ST_IDLE || state_q == ST_USE)) else $error("stray divide");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> !div_busy) else $error("divider busy at pixel");
	a_pixel_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> col_q < w_q && row_q < h_q) else $error("pixel off screen");
`endif
endmodule
`default_nettype wire

FILE: design/floor_ceiling_texture_caster.sv
// Floor and ceiling texture caster: top level with configuration registers.
// Depends on ffcc_pkg, ffcc_front, ffcc_back (and ffcc_div below it).
//
// Usage:
//  - s_* stream carries requests: tuser selects load floor texel, load ceiling
//    texel or render pixel; unknown kinds are dropped. Loads write a texture word.
//  - m_* stream carries two beats per render request: the floor write at (y,x),
//    then the ceiling write at (H-1-y,x) with tlast set.
//  - cfg_we/cfg_index/cfg_wdata write a register; write only while
//    the block is idle.
//  - A four-beat input queue lets loads and renders be taken while the back end
//    works or the receiver stalls; a full queue drops s_tready.
// Flow: an accepted beat leaves the queue when the back end is idle. A load is
// popped and written in the idle state. A render pixel runs pop, texture read and
// two output beats in turn, and the back end takes no new request until the
// second beat is registered. The first pixel of each row also runs the row
// set-up: two or three serial divisions (two on the horizon row) plus the shared
// multiplier.
// Reset: configuration returns to its defaults, the pixel counter to row 0,
// column 0; texture stores are undefined until loaded. A stalled receiver holds
// the current beat and the back end waits; nothing is dropped.
`default_nettype none
module floor_ceiling_texture_caster #(
	parameter int TEX_SIZE_LOG2 = 6,
	parameter int MAX_SCREEN    = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // texel_index[11:0], texel_color[43:12], zero pad
	input  wire logic [1:0]  s_tuser,   // req_type[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,   // screen_row[9:0], screen_column[19:10],
	                                    // pixel_color[51:20], zero pad
	output logic [0:0]       m_tuser,   // surface_kind[0]
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_wdata
);
	ffcc_pkg::cfg_t  cfg_q;
	ffcc_pkg::item_t q_item;
	ffcc_pkg::beat_t m_beat;
	logic            q_valid, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{screen_width: 11'd640, screen_height: 11'd480,
				view_pos_x: 24'd0, view_pos_y: 24'd0,
				view_dir_x: -16'sd16384, view_dir_y: 16'sd0,
				cam_plane_x: 16'sd0, cam_plane_y: 16'sd10813};
		end else if (cfg_we) begin
			unique case (cfg_index)
				ffcc_pkg::CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_wdata[10:0];
				ffcc_pkg::CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_wdata[10:0];
				ffcc_pkg::CFG_VIEW_POS_X:    cfg_q.view_pos_x    <= cfg_wdata;
				ffcc_pkg::CFG_VIEW_POS_Y:    cfg_q.view_pos_y    <= cfg_wdata;
				ffcc_pkg::CFG_VIEW_DIR_X:    cfg_q.view_dir_x    <= cfg_wdata[15:0];
				ffcc_pkg::CFG_VIEW_DIR_Y:    cfg_q.view_dir_y    <= cfg_wdata[15:0];
				ffcc_pkg::CFG_CAM_PLANE_X:   cfg_q.cam_plane_x   <= cfg_wdata[15:0];
				ffcc_pkg::CFG_CAM_PLANE_Y:   cfg_q.cam_plane_y   <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	ffcc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	ffcc_back #(
		.TEX_SIZE_LOG2(TEX_SIZE_LOG2),
		.MAX_SCREEN   (MAX_SCREEN)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_valid(q_valid),
		.q_item (q_item),
		.q_pop  (q_pop),
		.m_valid(m_tvalid),
		.m_beat (m_beat),
		.m_ready(m_tready)
	);

	assign m_tdata = {4'b0, m_beat.pixel_color, m_beat.screen_column, m_beat.screen_row};
	assign m_tuser = m_beat.surface_kind;
	assign m_tlast = m_beat.last_of_run;
endmodule
`default_nettype wire

FILE: verif/ffcc_checker.sv
// Checker for floor_ceiling_texture_caster: watches the config port and both streams,
// predicts the floor and ceiling writes and compares them beat by beat.
// Depends on ffcc_pkg.
`default_nettype none
module ffcc_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [47:0] s_tdata,
	input  wire logic [1:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [55:0] m_tdata,
	input  wire logic [0:0]  m_tuser,
	input  wire logic        m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_wdata,
	output int               pending,
	output int               errors
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SCREEN_MAX = 1024;

	ffcc_pkg::cfg_t   regs;
	logic [31:0]      floor_tex [4096];
	logic [31:0]      ceil_tex [4096];
	logic [10:0]      row_cnt, col_cnt;
	logic [47:0]      coord_x, coord_y, step_x, step_y;
	ffcc_pkg::beat_t  expected_writes[$];

	assign pending = expected_writes.size();

	function automatic longint sext16(logic [15:0] v);
		return longint'(signed'(v));
	endfunction

	function automatic int clamp_size(logic [10:0] v, int lo);
		if (int'(v) < lo)
			return lo;
		if (int'(v) > SCREEN_MAX)
			return SCREEN_MAX;
		return int'(v);
	endfunction

	// truncated texel fraction; negative coordinates fold as (-t) & (TEX-1)
	function automatic logic [5:0] texel_coord(logic [47:0] v);
		logic [47:0] m;
		logic [5:0]  t;
		if (v[47]) begin
			m = -v;
			t = m[23:18];
			return -t;
		end
		return v[23:18];
	endfunction

	task automatic begin_row(int w, int h);
		longint posz, p, rd, sx, sy;
		posz = h >> 1;
		p = longint'(row_cnt) - posz;
		rd = (p == 0) ? longint'(ffcc_pkg::RD_SAT) : (posz * 65536) / p;
		sx = longint'({regs.view_pos_x, 8'h00})
			+ (rd * (sext16(regs.view_dir_x) - sext16(regs.cam_plane_x))) / 64;
		sy = longint'({regs.view_pos_y, 8'h00})
			+ (rd * (sext16(regs.view_dir_y) - sext16(regs.cam_plane_y))) / 64;
		coord_x = sx[47:0];
		coord_y = sy[47:0];
		sx = (rd * 2 * sext16(regs.cam_plane_x)) / (longint'(w) * 64);
		sy = (rd * 2 * sext16(regs.cam_plane_y)) / (longint'(w) * 64);
		step_x = sx[47:0];
		step_y = sy[47:0];
	endtask

	task automatic render_pixel();
		int              w, h;
		logic [11:0]     addr;
		ffcc_pkg::beat_t b;
		w = clamp_size(regs.screen_width, 1);
		h = clamp_size(regs.screen_height, 2);
		if (int'(col_cnt) >= w) begin
			col_cnt = '0;
			row_cnt++;
		end
		if (int'(row_cnt) >= h)
			row_cnt = '0;
		if (col_cnt == 0)
			begin_row(w, h);
		addr = {texel_coord(coord_y), texel_coord(coord_x)};
		coord_x = coord_x + step_x;
		coord_y = coord_y + step_y;
		b.screen_row    = 10'(row_cnt);
		b.screen_column = 10'(col_cnt);
		b.pixel_color   = (floor_tex[addr] >> 1) & ffcc_pkg::DARKEN_MASK;
		b.surface_kind  = 1'b0;
		b.last_of_run   = 1'b0;
		expected_writes.push_back(b);
		b.screen_row    = 10'(h - 1 - int'(row_cnt));
		b.pixel_color   = (ceil_tex[addr] >> 1) & ffcc_pkg::DARKEN_MASK;
		b.surface_kind  = 1'b1;
		b.last_of_run   = 1'b1;
		expected_writes.push_back(b);
		col_cnt++;
		if (int'(col_cnt) >= w) begin
			col_cnt = '0;
			row_cnt++;
			if (int'(row_cnt) >= h)
				row_cnt = '0;
		end
	endtask

	task automatic note_error(string what, ffcc_pkg::beat_t exp_b, ffcc_pkg::beat_t got_b);
		errors++;
		if (errors <= 10)
			$display({"%t mismatch %s: expected row %0d col %0d colour %h kind %0d",
				" last %0d, got row %0d col %0d colour %h kind %0d last %0d"},
				$realtime, what, exp_b.screen_row, exp_b.screen_column, exp_b.pixel_color,
				exp_b.surface_kind, exp_b.last_of_run, got_b.screen_row,
				got_b.screen_column, got_b.pixel_color, got_b.surface_kind,
				got_b.last_of_run);
	endtask

	always @(posedge clk or negedge arst_n) begin
		ffcc_pkg::beat_t got_b, exp_b;
		if (!arst_n) begin
			regs.screen_width  = 11'd640;
			regs.screen_height = 11'd480;
			regs.view_pos_x    = '0;
			regs.view_pos_y    = '0;
			regs.view_dir_x    = -16'sd16384;
			regs.view_dir_y    = '0;
			regs.cam_plane_x   = '0;
			regs.cam_plane_y   = 16'sd10813;
			row_cnt = '0;
			col_cnt = '0;
			coord_x = '0;
			coord_y = '0;
			step_x  = '0;
			step_y  = '0;
			expected_writes.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				ffcc_pkg::CFG_SCREEN_WIDTH:  regs.screen_width  = cfg_wdata[10:0];
				ffcc_pkg::CFG_SCREEN_HEIGHT: regs.screen_height = cfg_wdata[10:0];
				ffcc_pkg::CFG_VIEW_POS_X:    regs.view_pos_x    = cfg_wdata;
				ffcc_pkg::CFG_VIEW_POS_Y:    regs.view_pos_y    = cfg_wdata;
				ffcc_pkg::CFG_VIEW_DIR_X:    regs.view_dir_x    = cfg_wdata[15:0];
				ffcc_pkg::CFG_VIEW_DIR_Y:    regs.view_dir_y    = cfg_wdata[15:0];
				ffcc_pkg::CFG_CAM_PLANE_X:   regs.cam_plane_x   = cfg_wdata[15:0];
				ffcc_pkg::CFG_CAM_PLANE_Y:   regs.cam_plane_y   = cfg_wdata[15:0];
				default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
				ffcc_pkg::REQ_LOAD_FLOOR: floor_tex[s_tdata[11:0]] = s_tdata[43:12];
				ffcc_pkg::REQ_LOAD_CEIL:  ceil_tex[s_tdata[11:0]]  = s_tdata[43:12];
				ffcc_pkg::REQ_RENDER:     render_pixel();
				default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got_b.screen_row    = m_tdata[9:0];
				got_b.screen_column = m_tdata[19:10];
				got_b.pixel_color   = m_tdata[51:20];
				got_b.surface_kind  = m_tuser[0];
				got_b.last_of_run   = m_tlast;
				if (expected_writes.size() == 0) begin
					note_error("unexpected beat", got_b, got_b);
				end else begin
					exp_b = expected_writes.pop_front();
					if (got_b !== exp_b)
						note_error("beat", exp_b, got_b);
				end
			end
		end
	end

	initial errors = 0;
endmodule
`default_nettype wire

FILE: verif/tb_floor_ceiling_texture_caster.sv
// Testbench top for floor_ceiling_texture_caster: clock, reset, stimulus and verdict.
// Depends on ffcc_pkg, the block and ffcc_checker, which does all checking.
`default_nettype none
module tb_floor_ceiling_texture_caster;
	timeunit 1ns;
	timeprecision 1ps;

	// request kind the block has to drop
	localparam logic [1:0] REQ_RESERVED = 2'd3;

	logic        clk, arst_n;
	logic        s_tvalid, s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid, m_tready;
	logic [55:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_wdata;
	int          pending, errors;
	bit          calm;       // no idling on either side
	bit          hold_rx;    // ask the receiver for one long hold-off

	floor_ceiling_texture_caster i_dut (.*);

	ffcc_checker i_checker (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb_floor_ceiling_texture_caster NOT OK");
		$finish;
	end

	// receiver: random gap before each beat, or one long hold when asked
	initial begin
		m_tready = 0;
		forever begin
			int n;
			if (hold_rx) begin
				m_tready <= 0;
				repeat (120) @(posedge clk);
				hold_rx = 0;
			end
			n = calm ? 0 : $urandom_range(0, 6);
			if (n > 0) begin
				m_tready <= 0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1;
			do
				@(posedge clk);
			while (!m_tvalid);
		end
	end

	task automatic send(logic [1:0] kind, logic [11:0] idx, logic [31:0] colour);
		int n;
		n = calm ? 0 : $urandom_range(0, 6);
		if (n > 0) begin
			s_tvalid <= 0;
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser  <= kind;
		s_tdata  <= {4'h0, colour, idx};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		do
			@(negedge clk);
		while (pending != 0);
		// loads leave no beat behind, so give the queue time to empty
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [23:0] val);
		@(posedge clk);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 0;
	endtask

	function automatic logic [23:0] pick_size(bit is_height);
		case ($urandom_range(0, 11))
		0: return 24'd0;
		1: return 24'd1;
		2: return 24'd2047;
		3: return 24'd1024;
		default: return is_height ? 24'($urandom_range(2, 9)) : 24'($urandom_range(1, 7));
		endcase
	endfunction

	function automatic logic [23:0] pick_vec();
		case ($urandom_range(0, 5))
		0: return 24'h008000;
		1: return 24'h007FFF;
		2: return 24'h000000;
		default: return 24'($urandom());
		endcase
	endfunction

	function automatic logic [23:0] pick_pos();
		case ($urandom_range(0, 4))
		0: return 24'h000000;
		1: return 24'hFFFFFF;
		default: return 24'($urandom());
		endcase
	endfunction

	task automatic random_setup();
		write_reg(ffcc_pkg::CFG_SCREEN_WIDTH, pick_size(0));
		write_reg(ffcc_pkg::CFG_SCREEN_HEIGHT, pick_size(1));
		write_reg(ffcc_pkg::CFG_VIEW_POS_X, pick_pos());
		write_reg(ffcc_pkg::CFG_VIEW_POS_Y, pick_pos());
		write_reg(ffcc_pkg::CFG_VIEW_DIR_X, pick_vec());
		write_reg(ffcc_pkg::CFG_VIEW_DIR_Y, pick_vec());
		write_reg(ffcc_pkg::CFG_CAM_PLANE_X, pick_vec());
		write_reg(ffcc_pkg::CFG_CAM_PLANE_Y, pick_vec());
	endtask

	task automatic random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			send(ffcc_pkg::REQ_RENDER, 12'($urandom()), $urandom());
		else if (r < 82)
			send(ffcc_pkg::REQ_LOAD_FLOOR, 12'($urandom()), $urandom());
		else if (r < 95)
			send(ffcc_pkg::REQ_LOAD_CEIL, 12'($urandom()), $urandom());
		else
			send(REQ_RESERVED, 12'($urandom()), $urandom());
	endtask

	initial begin
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_wdata = '0;
		calm = 1;
		hold_rx = 0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;

		// texture stores are undefined until loaded: fill both completely
		for (int i = 0; i < 4096; i++) begin
			send(ffcc_pkg::REQ_LOAD_FLOOR, 12'(i), $urandom());
			send(ffcc_pkg::REQ_LOAD_CEIL, 12'(i), $urandom());
		end
		calm = 0;

		// directed: default registers first, then extremes
		send(ffcc_pkg::REQ_RENDER, 12'h000, 32'h0);
		send(ffcc_pkg::REQ_RENDER, 12'hFFF, 32'hFFFFFFFF);
		send(ffcc_pkg::REQ_LOAD_FLOOR, 12'hFFF, 32'hFFFFFFFF);
		send(ffcc_pkg::REQ_LOAD_CEIL, 12'h000, 32'h00000000);
		send(REQ_RESERVED, 12'hABC, 32'h12345678);
		drain();
		// two-row screen: row 1 is the horizon; width zero clamps to one
		write_reg(ffcc_pkg::CFG_SCREEN_WIDTH, 24'd0);
		write_reg(ffcc_pkg::CFG_SCREEN_HEIGHT, 24'd1);
		write_reg(ffcc_pkg::CFG_VIEW_POS_X, 24'hFFFFFF);
		write_reg(ffcc_pkg::CFG_VIEW_POS_Y, 24'h000000);
		write_reg(ffcc_pkg::CFG_VIEW_DIR_X, 24'h008000);
		write_reg(ffcc_pkg::CFG_VIEW_DIR_Y, 24'h007FFF);
		write_reg(ffcc_pkg::CFG_CAM_PLANE_X, 24'h007FFF);
		write_reg(ffcc_pkg::CFG_CAM_PLANE_Y, 24'h008000);
		repeat (6) send(ffcc_pkg::REQ_RENDER, '0, '0);
		drain();
		// oversized screen clamps to the maximum; counter is at row 1, column 0
		write_reg(ffcc_pkg::CFG_SCREEN_WIDTH, 24'd2047);
		write_reg(ffcc_pkg::CFG_SCREEN_HEIGHT, 24'd2047);
		repeat (6) send(ffcc_pkg::REQ_RENDER, '0, '0);
		drain();

		for (int ph = 0; ph < 13; ph++) begin
			random_setup();
			calm = (ph % 5 == 3);
			for (int k = 0; k < 100; k++) begin
				if (ph == 2 && k == 10)
					hold_rx = 1;    // sender keeps offering until the queue fills
				if (ph == 4 && k == 50) begin
					s_tvalid <= 0;
					do
						@(negedge clk);
					while (pending != 0);
				end
				random_item();
			end
			drain();
		end

		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_floor_ceiling_texture_caster OK");
		else
			$display("tb_floor_ceiling_texture_caster NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
